@@ hdl/pir_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pir_pkg
// Types and constants shared by the PI regulator with deadband.
// ----------------------------------------------------------------------------
package pir_pkg;

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_P_GAIN         = 2'd0,
    REG_I_GAIN         = 2'd1,
    REG_INTEGRAL_LIMIT = 2'd2
  } pir_reg_t;

  localparam logic [15:0] P_GAIN_RESET    = 16'd256;
  localparam logic [15:0] I_GAIN_RESET    = 16'd0;
  localparam logic [11:0] LIMIT_RESET     = 12'd1000;

  localparam logic [7:0]  TARGET_FULL     = 8'd255;
  localparam logic [7:0]  CLAMP_LOW       = 8'd5;
  localparam logic [7:0]  TARGET_HIGH     = 8'd248;
  localparam logic [7:0]  DEADBAND        = 8'd5;

  // The sum is scaled by 5 * 256; at or above this it saturates the drive.
  localparam logic signed [30:0] NUM_SAT  = 31'sd327680;
  localparam logic [10:0] X_SAT           = 11'd1279;
  // floor(x / 5) = (x * 52429) >> 18 for every x below 1280.
  localparam logic [15:0] RECIP_FIVE      = 16'd52429;

  typedef struct packed {
    logic [7:0] target_raw;
    logic [7:0] measured;
  } pir_in_t;

  typedef struct packed {
    logic [7:0] drive;
    logic       direction;
  } pir_out_t;

  typedef struct packed {
    logic [15:0] p_gain;
    logic [15:0] i_gain;
    logic [11:0] integral_limit;
  } pir_cfg_t;

  // Error stage: magnitude, sign, deadband and saturation flags and the updated integral.
  typedef struct packed {
    logic [7:0]         err;
    logic               direction;
    logic               dead;
    logic               sat_pos;
    logic               sat_neg;
    logic signed [12:0] integ;
  } pir_err_t;

  // Product stage: proportional part (scaled by 5) and integral term, Q8.8.
  typedef struct packed {
    logic [26:0]        prop;
    logic signed [29:0] iterm;
    logic               direction;
  } pir_prod_t;

  // Clipped sum divided by 256, ready for the divide by five.
  typedef struct packed {
    logic [10:0] xq;
    logic        direction;
  } pir_clip_t;

endpackage

@@ hdl/pi_regulator_with_deadband.sv @@
`timescale 1ns / 1ps
// Path: input register, error register, product register, clip register, output register.
// Throughput: one word per cycle while out_ready is high; the integral update is the
// only loop and closes in the error stage.
// Reset clears all valid flags and the integral, and loads the gains and the
// limit with their reset values. The configuration port is always ready.
// ----------------------------------------------------------------------------
// pi_regulator_with_deadband
// PI regulator with deadband and integral clamp, one sample per word.
// ----------------------------------------------------------------------------
module pi_regulator_with_deadband (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  pir_pkg::pir_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output pir_pkg::pir_out_t out_data
);

  pir_pkg::pir_cfg_t  cfg;
  logic               err_valid;
  logic               err_ready;
  pir_pkg::pir_err_t  err_data;
  logic               prod_valid;
  logic               prod_ready;
  pir_pkg::pir_prod_t prod_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.p_gain         <= pir_pkg::P_GAIN_RESET;
      cfg.i_gain         <= pir_pkg::I_GAIN_RESET;
      cfg.integral_limit <= pir_pkg::LIMIT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pir_pkg::REG_P_GAIN:         cfg.p_gain         <= cfg_data;
        pir_pkg::REG_I_GAIN:         cfg.i_gain         <= cfg_data;
        pir_pkg::REG_INTEGRAL_LIMIT: cfg.integral_limit <= cfg_data[11:0];
        default: begin
        end
      endcase
    end
  end

  pir_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (err_valid),
    .out_ready (err_ready),
    .out_data  (err_data)
  );

  pir_mult u_mult (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (err_valid),
    .in_ready  (err_ready),
    .in_data   (err_data),
    .out_valid (prod_valid),
    .out_ready (prod_ready),
    .out_data  (prod_data)
  );

  pir_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prod_valid),
    .in_ready  (prod_ready),
    .in_data   (prod_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ hdl/pir_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pir_front
// Input register, target and measurement clamps, error and integral update.
// ----------------------------------------------------------------------------
module pir_front (
  input  logic              clk,
  input  logic              rst,
  input  pir_pkg::pir_cfg_t cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  pir_pkg::pir_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output pir_pkg::pir_err_t out_data
);

  logic               in_full;
  pir_pkg::pir_in_t   in_reg;
  logic               err_ready;
  logic               advance;
  logic signed [12:0] integ;
  logic signed [12:0] integ_next;

  logic [7:0]         t_inv;
  logic [7:0]         t_clamped;
  logic [7:0]         m_clamped;
  logic signed [9:0]  diff;
  logic signed [13:0] sum;
  logic signed [13:0] lim14;
  logic signed [12:0] lim13;
  logic               sat_pos;
  logic               sat_neg;
  pir_pkg::pir_err_t  err_next;

  assign err_ready = !out_valid || out_ready;
  assign in_ready  = !in_full || err_ready;
  assign advance   = in_full && err_ready;

  always_comb begin
    t_inv = pir_pkg::TARGET_FULL - in_reg.target_raw;
    priority if (t_inv > pir_pkg::TARGET_HIGH) begin
      t_clamped = pir_pkg::TARGET_HIGH;
    end else if (t_inv < pir_pkg::CLAMP_LOW) begin
      t_clamped = pir_pkg::CLAMP_LOW;
    end else begin
      t_clamped = t_inv;
    end
    m_clamped = (in_reg.measured < pir_pkg::CLAMP_LOW) ? pir_pkg::CLAMP_LOW
                                                        : in_reg.measured;

    diff  = signed'({2'b00, m_clamped}) - signed'({2'b00, t_clamped});
    sum   = 14'(integ) + 14'(diff);
    lim14 = signed'({2'b00, cfg.integral_limit});
    lim13 = signed'({1'b0, cfg.integral_limit});
    sat_pos = sum > lim14;
    sat_neg = sum < -lim14;

    priority if (sat_pos) begin
      integ_next = lim13;
    end else if (sat_neg) begin
      integ_next = -lim13;
    end else begin
      integ_next = sum[12:0];
    end

    err_next.direction = m_clamped > t_clamped;
    err_next.err       = err_next.direction ? (m_clamped - t_clamped)
                                            : (t_clamped - m_clamped);
    err_next.dead      = err_next.err < pir_pkg::DEADBAND;
    err_next.sat_pos   = sat_pos;
    err_next.sat_neg   = sat_neg;
    err_next.integ     = integ_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      out_valid <= 1'b0;
      integ     <= '0;
    end else begin
      if (in_ready) begin
        in_full <= in_valid;
      end
      if (err_ready) begin
        out_valid <= in_full;
      end
      if (advance) begin
        integ <= integ_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_reg <= in_data;
    end
    if (advance) begin
      out_data <= err_next;
    end
  end

`ifndef SYNTHESIS
  // After an update the integral lies within the limit in force at that time.
  a_integ_bounded: assert property (@(posedge clk) disable iff (rst)
    advance |=> (integ <= signed'({1'b0, $past(cfg.integral_limit)}) &&
                 integ >= -signed'({1'b0, $past(cfg.integral_limit)})))
    else $error("integral outside its limit after an update");

  // The integral only moves when a word leaves the input register.
  a_integ_holds: assert property (@(posedge clk) disable iff (rst)
    (!rst && !advance) |=> $stable(integ))
    else $error("integral changed without a word advancing");

  a_sat_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.sat_pos && out_data.sat_neg))
    else $error("integral saturated at both limits");
`endif

endmodule

@@ hdl/pir_mult.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pir_mult
// Proportional and integral products, each in its own multiplier.
// ----------------------------------------------------------------------------
module pir_mult (
  input  logic               clk,
  input  logic               rst,
  input  pir_pkg::pir_cfg_t  cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  pir_pkg::pir_err_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pir_pkg::pir_prod_t out_data
);

  logic [10:0]        err5;
  logic signed [29:0] ig_prod;
  logic signed [29:0] lim_term;
  pir_pkg::pir_prod_t prod_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    err5     = {1'b0, in_data.err, 2'b00} + {3'b000, in_data.err};
    ig_prod  = signed'({1'b0, cfg.i_gain}) * in_data.integ;
    lim_term = signed'({10'd0, cfg.integral_limit, 8'd0});

    prod_next.prop      = 27'(cfg.p_gain) * 27'(err5);
    prod_next.direction = in_data.direction;
    priority if (in_data.dead) begin
      prod_next.iterm = '0;
    end else if (in_data.sat_pos) begin
      prod_next.iterm = lim_term;
    end else if (in_data.sat_neg) begin
      prod_next.iterm = -lim_term;
    end else begin
      prod_next.iterm = ig_prod;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= prod_next;
    end
  end

endmodule

@@ hdl/pir_scale.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pir_scale
// Sum of the terms, saturation and the divide by 1280 into the drive word.
// ----------------------------------------------------------------------------
module pir_scale (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  pir_pkg::pir_prod_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pir_pkg::pir_out_t  out_data
);

  logic               clip_valid;
  logic               clip_ready;
  pir_pkg::pir_clip_t clip;
  pir_pkg::pir_clip_t clip_next;
  logic signed [30:0] num;
  logic [26:0]        quot;

  assign clip_ready = !out_valid || out_ready;
  assign in_ready   = !clip_valid || clip_ready;

  always_comb begin
    num = signed'({4'd0, in_data.prop}) + 31'(in_data.iterm);
    clip_next.direction = in_data.direction;
    // Clip to 0..1279 after dropping the Q8.8 fraction; 1279 / 5 gives 255.
    priority if (num <= 31'sd0) begin
      clip_next.xq = '0;
    end else if (num >= pir_pkg::NUM_SAT) begin
      clip_next.xq = pir_pkg::X_SAT;
    end else begin
      clip_next.xq = num[18:8];
    end
    quot = clip.xq * pir_pkg::RECIP_FIVE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_ready) begin
        clip_valid <= in_valid;
      end
      if (clip_ready) begin
        out_valid <= clip_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      clip <= clip_next;
    end
    if (clip_valid && clip_ready) begin
      out_data.drive     <= quot[25:18];
      out_data.direction <= clip.direction;
    end
  end

endmodule
